// File: hdl/nsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsm_pkg
// Shared types, constants and helpers of the nonoverlapping substring matcher
// ----------------------------------------------------------------------------
package nsm_pkg;

  // largest needle the register file can describe
  localparam int NEEDLE_BYTES_MAX = 32;
  localparam int MAX_NEEDLE_DEF   = 32;
  localparam int CFG_INDEX_W      = 3;
  localparam int CFG_DATA_W       = 64;
  localparam int NEEDLE_LEN_W     = 6;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NEEDLE_LENGTH  = 3'd0,
    REG_NEEDLE_BYTES_0 = 3'd1,
    REG_NEEDLE_BYTES_1 = 3'd2,
    REG_NEEDLE_BYTES_2 = 3'd3,
    REG_NEEDLE_BYTES_3 = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  text_byte;
    logic [15:0] byte_column;
    logic [15:0] row_number;
    logic        row_done;
  } text_item_t;

  typedef struct packed {
    logic [15:0] match_row;
    logic [15:0] start_column;
    logic [16:0] end_column;
  } match_item_t;

  // needle setup as seen by the match core
  typedef struct packed {
    logic [NEEDLE_LEN_W-1:0]       length;
    logic [NEEDLE_BYTES_MAX*8-1:0] bytes;
  } needle_cfg_t;

  function automatic logic [7:0] needle_byte(
    input logic [NEEDLE_BYTES_MAX*8-1:0] bytes,
    input logic [4:0]                    k
  );
    needle_byte = bytes[k*8 +: 8];
  endfunction

endpackage

// File: hdl/nsm_match_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsm_match_core
// Row window, parallel needle compare and skip tracking, one byte per advance
// ----------------------------------------------------------------------------
module nsm_match_core #(
  parameter int MAX_NEEDLE = nsm_pkg::MAX_NEEDLE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  nsm_pkg::text_item_t  item,
  input  nsm_pkg::needle_cfg_t needle,
  output logic                 hit,
  output nsm_pkg::match_item_t result
);

  localparam int CW = $clog2(MAX_NEEDLE + 1);
  localparam int IW = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;

  logic [7:0]  win_bytes      [MAX_NEEDLE];
  logic [15:0] win_cols       [MAX_NEEDLE];
  logic [7:0]  win_bytes_next [MAX_NEEDLE];
  logic [15:0] win_cols_next  [MAX_NEEDLE];

  logic [CW-1:0] bytes_in_row, bytes_in_row_next, count_inc;
  logic [CW-1:0] skip_remaining, skip_remaining_next;

  logic [5:0]            len_sat;
  logic [5:0]            len_m1;
  logic [MAX_NEEDLE-1:0] pos_ok;
  logic                  window_ok;

  // needle length saturates at the window depth
  assign len_sat = (needle.length > 6'(MAX_NEEDLE)) ? 6'(MAX_NEEDLE) : needle.length;
  assign len_m1  = len_sat - 6'd1;

  always_comb begin
    win_bytes_next[0] = item.text_byte;
    win_cols_next[0]  = item.byte_column;
    for (int j = 1; j < MAX_NEEDLE; j++) begin
      win_bytes_next[j] = win_bytes[j-1];
      win_cols_next[j]  = win_cols[j-1];
    end
  end

  // window slot j holds needle byte len-1-j
  always_comb begin
    logic [5:0] k;
    for (int j = 0; j < MAX_NEEDLE; j++) begin
      k         = len_m1 - 6'(j);
      pos_ok[j] = (len_sat <= 6'(j)) ||
                  (win_bytes_next[j] == nsm_pkg::needle_byte(needle.bytes, k[4:0]));
    end
  end

  assign count_inc = (bytes_in_row < CW'(MAX_NEEDLE)) ? bytes_in_row + CW'(1) : bytes_in_row;
  assign window_ok = (len_sat != 6'd0) && (6'(count_inc) >= len_sat) && (&pos_ok);
  assign hit       = (skip_remaining == '0) && window_ok;

  always_comb begin
    bytes_in_row_next = count_inc;
    if (skip_remaining != '0) begin
      skip_remaining_next = skip_remaining - CW'(1);
    end else if (window_ok) begin
      skip_remaining_next = CW'(len_m1);
    end else begin
      skip_remaining_next = '0;
    end
    if (item.row_done) begin
      bytes_in_row_next   = '0;
      skip_remaining_next = '0;
    end
  end

  assign result.match_row    = item.row_number;
  assign result.start_column = win_cols_next[IW'(len_m1)];
  assign result.end_column   = {1'b0, item.byte_column} + 17'd1;

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int j = 0; j < MAX_NEEDLE; j++) begin
        win_bytes[j] <= win_bytes_next[j];
        win_cols[j]  <= win_cols_next[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_row   <= '0;
      skip_remaining <= '0;
    end else if (advance) begin
      bytes_in_row   <= bytes_in_row_next;
      skip_remaining <= skip_remaining_next;
    end
  end

  // row end clears the row state
  a_row_clear: assert property (@(posedge clk) disable iff (rst)
    advance && item.row_done |=> bytes_in_row == '0 && skip_remaining == '0)
    else $error("row state not cleared at row end");

  // a fresh match covers the rest of the needle
  a_skip_load: assert property (@(posedge clk) disable iff (rst)
    advance && hit && !item.row_done |=> skip_remaining == $past(CW'(len_m1)))
    else $error("skip count not loaded after match");

  // skip count only counts down while covered bytes pass
  a_skip_down: assert property (@(posedge clk) disable iff (rst)
    advance && skip_remaining != '0 && !item.row_done
      |=> skip_remaining == $past(skip_remaining) - CW'(1))
    else $error("skip count did not step down");

endmodule

// File: hdl/nonoverlapping_substring_matcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonoverlapping_substring_matcher_unit
// Leftmost nonoverlapping needle search in row text, unstalled one byte per clock
// ----------------------------------------------------------------------------
//  channel  | valid       | stall       | payload     | transaction
//  ---------+-------------+-------------+-------------+---------------------------
//  text     | text_valid  | text_stall  | text_item   | one text byte with column
//  match    | match_valid | match_stall | match_item  | one reported occurrence
//  config   | cfg_write   | (none)      | cfg_index/  | one register write
//           |             |             | cfg_data    |
//
//  a byte accepted into the input register passes the window compare and, on a
//  match, is loaded into the result register; a new byte is taken every cycle
//  unless text_stall is high
//  rst is synchronous: needle length returns to 1, needle bytes to zero,
//  row count and skip count to zero, both pipeline registers empty
//  match_stall holds a waiting result and, with a byte also waiting, text_stall
// ----------------------------------------------------------------------------
module nonoverlapping_substring_matcher_unit #(
  parameter int MAX_NEEDLE = nsm_pkg::MAX_NEEDLE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // text byte channel
  input  logic                            text_valid,
  output logic                            text_stall,
  input  nsm_pkg::text_item_t             text_item,
  // match result channel
  output logic                            match_valid,
  input  logic                            match_stall,
  output nsm_pkg::match_item_t            match_item,
  // configuration write port
  input  logic                            cfg_write,
  input  logic [nsm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [nsm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [nsm_pkg::NEEDLE_LEN_W-1:0] needle_length;
  logic [nsm_pkg::CFG_DATA_W-1:0]   needle_word [4];
  nsm_pkg::needle_cfg_t             needle;

  // input register
  nsm_pkg::text_item_t text_q;
  logic                text_q_valid;
  logic                text_take;

  // core interface
  logic                 advance;
  logic                 core_hit;
  nsm_pkg::match_item_t core_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_length <= nsm_pkg::NEEDLE_LEN_W'(1);
      for (int w = 0; w < 4; w++) begin
        needle_word[w] <= '0;
      end
    end else if (cfg_write) begin
      unique case (nsm_pkg::cfg_reg_t'(cfg_index))
        nsm_pkg::REG_NEEDLE_LENGTH:  needle_length  <= cfg_data[nsm_pkg::NEEDLE_LEN_W-1:0];
        nsm_pkg::REG_NEEDLE_BYTES_0: needle_word[0] <= cfg_data;
        nsm_pkg::REG_NEEDLE_BYTES_1: needle_word[1] <= cfg_data;
        nsm_pkg::REG_NEEDLE_BYTES_2: needle_word[2] <= cfg_data;
        nsm_pkg::REG_NEEDLE_BYTES_3: needle_word[3] <= cfg_data;
        default: ; // unknown index, write dropped
      endcase
    end
  end

  // byte k of the needle sits at bit 8k of the concatenated words
  assign needle.length = needle_length;
  assign needle.bytes  = {needle_word[3], needle_word[2], needle_word[1], needle_word[0]};

  // the byte in the input register moves on whenever the result register
  // is free or being emptied this cycle
  assign advance    = text_q_valid && (!match_valid || !match_stall);
  assign text_stall = text_q_valid && !advance;
  assign text_take  = text_valid && !text_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_q_valid <= 1'b0;
    end else if (text_take) begin
      text_q_valid <= 1'b1;
    end else if (advance) begin
      text_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_take) begin
      text_q <= text_item;
    end
  end

  nsm_match_core #(
    .MAX_NEEDLE (MAX_NEEDLE)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (text_q),
    .needle  (needle),
    .hit     (core_hit),
    .result  (core_result)
  );

  // result register: loads on a match, empties when the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      match_valid <= 1'b0;
    end else if (advance && core_hit) begin
      match_valid <= 1'b1;
    end else if (!match_stall) begin
      match_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_hit) begin
      match_item <= core_result;
    end
  end

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    match_valid && match_stall |-> !advance)
    else $error("result register overwritten while stalled");

  // input side only stalls with a byte waiting in the input register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> text_q_valid && match_valid && match_stall)
    else $error("text stall without a blocked pipeline");

  // end column is last column plus one, never wraps to zero
  a_end_nonzero: assert property (@(posedge clk) disable iff (rst)
    match_valid |-> match_item.end_column != 17'd0)
    else $error("end column of zero reported");

  // a taken byte sits in the input register in the following cycle
  a_flow: assert property (@(posedge clk) disable iff (rst)
    text_take |=> text_q_valid)
    else $error("accepted byte lost from input register");

endmodule
